// ===== hdl/ppu_pkg.sv =====
// Shared types and constants of the particle pool update unit.
`default_nettype none
package ppu_pkg;

	localparam logic [1:0] KIND_EMIT  = 2'd0;
	localparam logic [1:0] KIND_TICK  = 2'd1;
	localparam logic [1:0] KIND_QUERY = 2'd2;

	localparam logic [2:0] REG_COLOR_BEGIN    = 3'd0;
	localparam logic [2:0] REG_COLOR_END      = 3'd1;
	localparam logic [2:0] REG_SIZE_END       = 3'd2;
	localparam logic [2:0] REG_SIZE_JITTER    = 3'd3;
	localparam logic [2:0] REG_SPEED_JITTER_X = 3'd4;
	localparam logic [2:0] REG_SPEED_JITTER_Y = 3'd5;
	localparam logic [2:0] REG_LIFETIME       = 3'd6;

	localparam logic [31:0] RST_COLOR_BEGIN = 32'hFFFF_FFFF;
	localparam logic [30:0] RST_LIFETIME    = 31'd65536;

	localparam logic [31:0] TWO_PI_Q16 = 32'd411775;
	localparam logic [16:0] HALF_Q16   = 17'd32768;
	localparam logic [16:0] ONE_Q16    = 17'd65536;
	// ceil(2^37 / 100): (ts * ANGLE_RECIP) >> 37 is floor(ts / 100) for any 31-bit ts
	localparam logic [31:0] ANGLE_RECIP = 32'h51EB_851F;

	localparam int MUL_AW = 34;
	localparam int MUL_BW = 32;
	localparam int MUL_PW = MUL_AW + MUL_BW;
	localparam int NUM_W  = 48;
	localparam int DEN_W  = 31;
	localparam int SAT_W  = 51;

	typedef struct packed {
		logic [31:0] color_begin;
		logic [31:0] color_end;
		logic [31:0] size_end;
		logic [31:0] size_jitter;
		logic [31:0] speed_jitter_x;
		logic [31:0] speed_jitter_y;
		logic [30:0] lifetime;
	} cfg_t;

	typedef struct packed {
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] vel_x;
		logic [31:0] vel_y;
		logic [31:0] angle;
		logic [31:0] size_b;
		logic [31:0] life_total;
		logic [31:0] life_left;
	} rec_t;

	// clamp a signed value to the 32-bit signed range
	function automatic logic [31:0] sat32(input logic [SAT_W-1:0] v);
		logic [SAT_W-32:0] top;
		top = v[SAT_W-1:31];
		if (top == '0 || top == '1) begin
			return v[31:0];
		end
		return v[SAT_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/ppu_mul.sv =====
// Shared signed multiplier with registered product.
`default_nettype none
module ppu_mul (
	input  wire logic                           clk,
	input  wire logic [ppu_pkg::MUL_AW-1:0]     a,
	input  wire logic [ppu_pkg::MUL_BW-1:0]     b,
	output logic      [ppu_pkg::MUL_PW-1:0]     p_q
);

	always_ff @(posedge clk) begin
		p_q <= ppu_pkg::MUL_PW'($signed(a) * $signed(b));
	end

endmodule
`default_nettype wire

// ===== hdl/ppu_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module ppu_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [ppu_pkg::NUM_W-1:0]    dividend,
	input  wire logic [ppu_pkg::DEN_W-1:0]    divisor,
	output logic                              done,
	output logic      [ppu_pkg::NUM_W-1:0]    quotient
);

	localparam int CW = $clog2(ppu_pkg::NUM_W);

	logic [ppu_pkg::DEN_W-1:0] den_q;
	logic [ppu_pkg::DEN_W-1:0] rem_q;
	logic [ppu_pkg::NUM_W-1:0] quo_q;
	logic [CW-1:0]             cnt_q;
	logic                      run_q;
	logic [ppu_pkg::DEN_W:0]   trial;
	logic [ppu_pkg::DEN_W:0]   diff;
	logic                      fits;

	// remainder stays below the divisor, so DEN_W bits hold it
	assign trial = {rem_q, quo_q[ppu_pkg::NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(ppu_pkg::NUM_W - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (run_q) begin
			rem_q <= fits ? diff[ppu_pkg::DEN_W-1:0] : trial[ppu_pkg::DEN_W-1:0];
			quo_q <= {quo_q[ppu_pkg::NUM_W-2:0], fits};
		end
	end

endmodule
`default_nettype wire

// ===== hdl/ppu_core.sv =====
// Pool memories and sequencer driving the shared multiplier and divider.
`default_nettype none
module ppu_core #(
	parameter int POOL_SIZE = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire ppu_pkg::cfg_t        cfg,
	input  wire logic                 start,
	input  wire logic [1:0]           kind,
	input  wire logic [5:0]           slot,
	input  wire logic [31:0]          start_x,
	input  wire logic [31:0]          start_y,
	input  wire logic [31:0]          base_speed_x,
	input  wire logic [31:0]          base_speed_y,
	input  wire logic [31:0]          birth_size,
	input  wire logic [15:0]          rand_angle,
	input  wire logic [15:0]          rand_vx,
	input  wire logic [15:0]          rand_vy,
	input  wire logic [15:0]          rand_size,
	input  wire logic [30:0]          time_step,
	output logic                      busy,
	output logic                      done,
	output logic                      alive,
	output logic [31:0]               out_x,
	output logic [31:0]               out_y,
	output logic [31:0]               out_angle,
	output logic [31:0]               out_size,
	output logic [31:0]               out_color
);

	localparam int IW = $clog2(POOL_SIZE);

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE,
		S_EM_ANG, S_EM_VX, S_EM_VY, S_EM_SZ, S_EM_WR,
		S_T_DIV, S_T_ANG, S_T_MX, S_T_MY, S_T_WR,
		S_R_CHK, S_R_DIV, S_R_M0, S_R_M1, S_R_M2, S_R_M3, S_R_M4, S_R_FIN
	} state_t;

	state_t state_q;

	// pool storage
	ppu_pkg::rec_t rec_mem [POOL_SIZE];
	logic          act_mem [POOL_SIZE];
	ppu_pkg::rec_t rec_rd_q;
	logic          act_rd_q;

	logic          rd_en;
	logic [IW-1:0] rd_addr;
	logic          rec_we;
	logic          act_we;
	logic          act_wd;
	logic [IW-1:0] wr_addr;
	ppu_pkg::rec_t rec_wd;

	// latched request
	logic [31:0] sx_q, sy_q, bvx_q, bvy_q, bsz_q;
	logic [15:0] ra_q, rvx_q, rvy_q, rsz_q;
	logic [30:0] ts_q;
	logic        in_range_q;

	logic [IW-1:0] idx_q;
	logic [IW-1:0] next_slot_q;
	logic [31:0]   ang_q, vx_q, vy_q, px_q, dang_q, size_q, col_q;
	logic [16:0]   w_q;

	logic [ppu_pkg::MUL_AW-1:0] mul_a;
	logic [ppu_pkg::MUL_BW-1:0] mul_b;
	logic [ppu_pkg::MUL_PW-1:0] mul_p;

	logic                        div_start;
	logic [ppu_pkg::NUM_W-1:0]   div_num;
	logic [ppu_pkg::DEN_W-1:0]   div_den;
	logic                        div_done;
	logic [ppu_pkg::NUM_W-1:0]   div_q;

	logic [31:0]               add_b;
	logic [ppu_pkg::SAT_W-1:0] sum;
	logic [31:0]               sat_out;
	logic [12:0]               slot_w;
	logic                      ll_le0;
	logic                      ll_full;
	logic [7:0]                lane_b;
	logic [7:0]                lane_e;
	logic [7:0]                lane_out;
	logic [16:0]               rvx_c, rvy_c, rsz_c;

	ppu_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_p)
	);

	ppu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (div_q)
	);

	assign busy   = (state_q != S_IDLE);
	assign slot_w = {7'd0, slot};

	assign ll_le0  = rec_rd_q.life_left[31] || (rec_rd_q.life_left == '0);
	assign ll_full = $signed(rec_rd_q.life_left) >= $signed(rec_rd_q.life_total);

	assign rvx_c = {1'b0, rvx_q} - ppu_pkg::HALF_Q16;
	assign rvy_c = {1'b0, rvy_q} - ppu_pkg::HALF_Q16;
	assign rsz_c = {1'b0, rsz_q} - ppu_pkg::HALF_Q16;

	// multiplier operand select
	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		lane_b = '0;
		lane_e = '0;
		unique case (state_q)
			S_R_M1: begin
				lane_b = cfg.color_begin[7:0];
				lane_e = cfg.color_end[7:0];
			end
			S_R_M2: begin
				lane_b = cfg.color_begin[15:8];
				lane_e = cfg.color_end[15:8];
			end
			S_R_M3: begin
				lane_b = cfg.color_begin[23:16];
				lane_e = cfg.color_end[23:16];
			end
			S_R_M4: begin
				lane_b = cfg.color_begin[31:24];
				lane_e = cfg.color_end[31:24];
			end
			default: begin
			end
		endcase
		unique case (state_q)
			S_EM_ANG: begin
				mul_a = {18'd0, ra_q};
				mul_b = ppu_pkg::TWO_PI_Q16;
			end
			S_EM_VX: begin
				mul_a = {{2{cfg.speed_jitter_x[31]}}, cfg.speed_jitter_x};
				mul_b = {{15{rvx_c[16]}}, rvx_c};
			end
			S_EM_VY: begin
				mul_a = {{2{cfg.speed_jitter_y[31]}}, cfg.speed_jitter_y};
				mul_b = {{15{rvy_c[16]}}, rvy_c};
			end
			S_EM_SZ: begin
				mul_a = {{2{cfg.size_jitter[31]}}, cfg.size_jitter};
				mul_b = {{15{rsz_c[16]}}, rsz_c};
			end
			S_T_DIV: begin
				mul_a = {3'd0, ts_q};
				mul_b = ppu_pkg::ANGLE_RECIP;
			end
			S_T_MX: begin
				mul_a = {{2{rec_rd_q.vel_x[31]}}, rec_rd_q.vel_x};
				mul_b = {1'b0, ts_q};
			end
			S_T_MY: begin
				mul_a = {{2{rec_rd_q.vel_y[31]}}, rec_rd_q.vel_y};
				mul_b = {1'b0, ts_q};
			end
			S_R_M0: begin
				mul_a = {{2{rec_rd_q.size_b[31]}}, rec_rd_q.size_b}
				      - {{2{cfg.size_end[31]}}, cfg.size_end};
				mul_b = {15'd0, w_q};
			end
			S_R_M1, S_R_M2, S_R_M3, S_R_M4: begin
				mul_a = {26'd0, lane_b} - {26'd0, lane_e};
				mul_b = {15'd0, w_q};
			end
			default: begin
			end
		endcase
	end

	// product >> 16 plus addend, then clamp
	always_comb begin
		unique case (state_q)
			S_EM_VY: add_b = bvx_q;
			S_EM_SZ: add_b = bvy_q;
			S_EM_WR: add_b = bsz_q;
			S_T_MY:  add_b = rec_rd_q.pos_x;
			S_T_WR:  add_b = rec_rd_q.pos_y;
			default: add_b = '0;
		endcase
		sum = {mul_p[ppu_pkg::MUL_PW-1], mul_p[ppu_pkg::MUL_PW-1:16]}
		    + {{(ppu_pkg::SAT_W-32){add_b[31]}}, add_b};
		sat_out = ppu_pkg::sat32(sum);
	end

	// colour lane held in the product belongs to the previous state's lane
	always_comb begin
		unique case (state_q)
			S_R_M2:  lane_out = cfg.color_end[7:0] + mul_p[23:16];
			S_R_M3:  lane_out = cfg.color_end[15:8] + mul_p[23:16];
			S_R_M4:  lane_out = cfg.color_end[23:16] + mul_p[23:16];
			default: lane_out = cfg.color_end[31:24] + mul_p[23:16];
		endcase
	end

	// divider request: render weight
	always_comb begin
		div_start = 1'b0;
		div_num   = {rec_rd_q.life_left, 16'd0};
		div_den   = rec_rd_q.life_total[30:0];
		if (state_q == S_R_CHK) begin
			div_start = in_range_q && act_rd_q && !ll_le0 && !ll_full;
		end
	end

	// memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_q;
		rec_we  = 1'b0;
		act_we  = 1'b0;
		act_wd  = 1'b0;
		wr_addr = idx_q;
		rec_wd  = rec_rd_q;
		unique case (state_q)
			S_CLEAR: begin
				act_we = 1'b1;
			end
			S_IDLE: begin
				rd_en   = start && (kind == ppu_pkg::KIND_QUERY);
				rd_addr = slot_w[IW-1:0];
			end
			S_T_DIV: begin
				rd_en   = 1'b1;
				rd_addr = '0;
			end
			S_T_WR: begin
				rd_en   = (idx_q != IW'(POOL_SIZE - 1));
				rd_addr = idx_q + 1'b1;
				if (act_rd_q) begin
					if (ll_le0) begin
						act_we = 1'b1;
					end else begin
						rec_we           = 1'b1;
						rec_wd.pos_x     = px_q;
						rec_wd.pos_y     = sat_out;
						rec_wd.angle     = rec_rd_q.angle + dang_q;
						rec_wd.life_left = rec_rd_q.life_left - {1'b0, ts_q};
					end
				end
			end
			S_EM_WR: begin
				rec_we            = 1'b1;
				act_we            = 1'b1;
				act_wd            = 1'b1;
				wr_addr           = next_slot_q;
				rec_wd.pos_x      = sx_q;
				rec_wd.pos_y      = sy_q;
				rec_wd.vel_x      = vx_q;
				rec_wd.vel_y      = vy_q;
				rec_wd.angle      = ang_q;
				rec_wd.size_b     = sat_out;
				rec_wd.life_total = {1'b0, cfg.lifetime};
				rec_wd.life_left  = {1'b0, cfg.lifetime};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rec_we) begin
			rec_mem[wr_addr] <= rec_wd;
		end
		if (rd_en) begin
			rec_rd_q <= rec_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (act_we) begin
			act_mem[wr_addr] <= act_wd;
		end
		if (rd_en) begin
			act_rd_q <= act_mem[rd_addr];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			idx_q       <= '0;
			next_slot_q <= IW'(POOL_SIZE - 1);
			done        <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == IW'(POOL_SIZE - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						unique case (kind)
							ppu_pkg::KIND_EMIT:  state_q <= S_EM_ANG;
							ppu_pkg::KIND_TICK:  state_q <= S_T_DIV;
							ppu_pkg::KIND_QUERY: state_q <= S_R_CHK;
							default:             state_q <= S_IDLE;
						endcase
					end
				end
				S_EM_ANG: state_q <= S_EM_VX;
				S_EM_VX:  state_q <= S_EM_VY;
				S_EM_VY:  state_q <= S_EM_SZ;
				S_EM_SZ:  state_q <= S_EM_WR;
				S_EM_WR: begin
					next_slot_q <= (next_slot_q == '0) ? IW'(POOL_SIZE - 1)
					                                   : next_slot_q - 1'b1;
					state_q     <= S_IDLE;
				end
				S_T_DIV: begin
					idx_q   <= '0;
					state_q <= S_T_ANG;
				end
				S_T_ANG: state_q <= S_T_MX;
				S_T_MX: state_q <= S_T_MY;
				S_T_MY: state_q <= S_T_WR;
				S_T_WR: begin
					if (idx_q == IW'(POOL_SIZE - 1)) begin
						state_q <= S_IDLE;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_T_MX;
					end
				end
				S_R_CHK: begin
					if (!in_range_q || !act_rd_q) begin
						done      <= 1'b1;
						alive     <= 1'b0;
						out_x     <= '0;
						out_y     <= '0;
						out_angle <= '0;
						out_size  <= '0;
						out_color <= '0;
						state_q   <= S_IDLE;
					end else if (div_start) begin
						state_q <= S_R_DIV;
					end else begin
						state_q <= S_R_M0;
					end
				end
				S_R_DIV: begin
					if (div_done) begin
						state_q <= S_R_M0;
					end
				end
				S_R_M0: state_q <= S_R_M1;
				S_R_M1: state_q <= S_R_M2;
				S_R_M2: state_q <= S_R_M3;
				S_R_M3: state_q <= S_R_M4;
				S_R_M4: state_q <= S_R_FIN;
				S_R_FIN: begin
					done      <= 1'b1;
					alive     <= 1'b1;
					out_x     <= rec_rd_q.pos_x;
					out_y     <= rec_rd_q.pos_y;
					out_angle <= rec_rd_q.angle;
					out_size  <= size_q;
					out_color <= {lane_out, col_q[31:8]};
					state_q   <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			sx_q       <= start_x;
			sy_q       <= start_y;
			bvx_q      <= base_speed_x;
			bvy_q      <= base_speed_y;
			bsz_q      <= birth_size;
			ra_q       <= rand_angle;
			rvx_q      <= rand_vx;
			rvy_q      <= rand_vy;
			rsz_q      <= rand_size;
			ts_q       <= time_step;
			in_range_q <= slot_w < 13'(POOL_SIZE);
		end
		unique case (state_q)
			S_EM_VX: ang_q  <= mul_p[47:16];
			S_EM_VY: vx_q   <= sat_out;
			S_EM_SZ: vy_q   <= sat_out;
			S_T_ANG: dang_q <= {7'd0, mul_p[61:37]};
			S_T_WR:  px_q   <= px_q;
			S_T_MY:  px_q   <= sat_out;
			S_R_CHK: w_q    <= ll_le0 ? 17'd0 : ppu_pkg::ONE_Q16;
			S_R_DIV: begin
				if (div_done) begin
					w_q <= div_q[16:0];
				end
			end
			S_R_M1: size_q <= cfg.size_end + mul_p[47:16];
			S_R_M2, S_R_M3, S_R_M4: col_q <= {lane_out, col_q[31:8]};
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== hdl/particle_pool_update_unit.sv =====
// Particle pool update unit: configuration registers and pool engine.
// Emit: the angle, x speed, y speed and size each use the shared multiplier, then
// the record is written. Tick: one reciprocal multiply for the angle step, then
// each slot takes its x and y multiplies and a write-back. Query: the result
// strobe comes straight from the check for an empty slot; a full or expired weight
// skips the divider, while other weights take the life ratio through it. Reset clears
// registers, then sweeps the active flags with busy high; results cannot be stalled.
`default_nettype none
module particle_pool_update_unit #(
	parameter int POOL_SIZE = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  kind,
	input  wire logic [5:0]  slot,
	input  wire logic [31:0] start_x,
	input  wire logic [31:0] start_y,
	input  wire logic [31:0] base_speed_x,
	input  wire logic [31:0] base_speed_y,
	input  wire logic [31:0] birth_size,
	input  wire logic [15:0] rand_angle,
	input  wire logic [15:0] rand_vx,
	input  wire logic [15:0] rand_vy,
	input  wire logic [15:0] rand_size,
	input  wire logic [30:0] time_step,
	output logic             done,
	output logic             alive,
	output logic [31:0]      out_x,
	output logic [31:0]      out_y,
	output logic [31:0]      out_angle,
	output logic [31:0]      out_size,
	output logic [31:0]      out_color
);

	ppu_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.color_begin    <= ppu_pkg::RST_COLOR_BEGIN;
			cfg_q.color_end      <= '0;
			cfg_q.size_end       <= '0;
			cfg_q.size_jitter    <= '0;
			cfg_q.speed_jitter_x <= '0;
			cfg_q.speed_jitter_y <= '0;
			cfg_q.lifetime       <= ppu_pkg::RST_LIFETIME;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ppu_pkg::REG_COLOR_BEGIN:    cfg_q.color_begin    <= cfg_data;
				ppu_pkg::REG_COLOR_END:      cfg_q.color_end      <= cfg_data;
				ppu_pkg::REG_SIZE_END:       cfg_q.size_end       <= cfg_data;
				ppu_pkg::REG_SIZE_JITTER:    cfg_q.size_jitter    <= cfg_data;
				ppu_pkg::REG_SPEED_JITTER_X: cfg_q.speed_jitter_x <= cfg_data;
				ppu_pkg::REG_SPEED_JITTER_Y: cfg_q.speed_jitter_y <= cfg_data;
				ppu_pkg::REG_LIFETIME:       cfg_q.lifetime       <= cfg_data[30:0];
				default: begin
				end
			endcase
		end
	end

	ppu_core #(
		.POOL_SIZE (POOL_SIZE)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.start        (start),
		.kind         (kind),
		.slot         (slot),
		.start_x      (start_x),
		.start_y      (start_y),
		.base_speed_x (base_speed_x),
		.base_speed_y (base_speed_y),
		.birth_size   (birth_size),
		.rand_angle   (rand_angle),
		.rand_vx      (rand_vx),
		.rand_vy      (rand_vy),
		.rand_size    (rand_size),
		.time_step    (time_step),
		.busy         (busy),
		.done         (done),
		.alive        (alive),
		.out_x        (out_x),
		.out_y        (out_y),
		.out_angle    (out_angle),
		.out_size     (out_size),
		.out_color    (out_color)
	);

`ifndef ASSERT_OFF
	// a result only ever follows a request in flight
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a request in progress");

	// a tick request always occupies the engine
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && kind == ppu_pkg::KIND_TICK) |=> busy)
		else $error("tick request did not start the slot sweep");

	// an empty slot answers with all fields cleared
	a_dead_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !alive) |-> (out_x == '0 && out_y == '0 && out_angle == '0 &&
			out_size == '0 && out_color == '0))
		else $error("inactive slot returned non-zero fields");
`endif

endmodule
`default_nettype wire
